// ===== hdl/wps_pkg.sv =====
// Shared widths, codes and types for the weighted profile bin statistics block.
package wps_pkg;

  localparam int VW      = 24;              // sample value width
  localparam int CW      = 32;              // entry counter width
  localparam int WW      = 16;              // weight width
  localparam int SFW     = 24;              // scale factor width
  localparam int SUM_W   = 64;              // weighted sum width
  localparam int SQ_W    = 63;              // weighted square sum width
  localparam int MEAN_W  = 48;
  localparam int SD_W    = 40;
  localparam int MUL_W   = 64;              // serial multiplier operand width
  localparam int DIV_W   = 96;              // serial divider numerator width
  localparam int STEP_W  = $clog2(DIV_W + 1);
  localparam int MSTEP_W = $clog2(MUL_W);
  localparam int FP_W    = 2 * VW + WW + 1; // fill square product plus rounding carry

  localparam logic [SQ_W-1:0] SQ_MAX  = {SQ_W{1'b1}};
  localparam logic [CW-1:0]   CNT_MAX = {CW{1'b1}};

  typedef enum logic [1:0] {
    REQ_FILL  = 2'd0,
    REQ_SCALE = 2'd1,
    REQ_MERGE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_SINGLE = 2'd2,
    ST_NEGVAR = 2'd3
  } status_t;

  // status of an iterative arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== hdl/weighted_profile_bin_stats.sv =====
// Top level: weighted profile bin accumulator with serial mean, variance and root units.
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  input   | in_valid, in_stall, in_req_type .. in_merge_sumsq  | in
//  result  | out_valid, out_stall, out_count .. out_status      | out
//
// An empty bin needs no arithmetic, a single-entry bin one 64-bit serial division, and
// any other bin two 64x64 serial products, a 64-bit and two 96-bit serial divisions and
// two 48-step roots; a scale request adds two serial products. Reset (synchronous,
// rst_n low) clears the counter and both sums.
// The result register frees the core: a new transfer is taken while the last result
// waits under out_stall; a second result waits in the done state.
module weighted_profile_bin_stats (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [wps_pkg::VW-1:0]        in_value,
  input  logic [wps_pkg::WW-1:0]        in_weight,
  input  logic [wps_pkg::SFW-1:0]       in_scale_factor,
  input  logic [31:0]                   in_merge_count,
  input  logic [wps_pkg::SUM_W-1:0]     in_merge_sum,
  input  logic [wps_pkg::SQ_W-1:0]      in_merge_sumsq,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_count,
  output logic [wps_pkg::MEAN_W-1:0]    out_mean,
  output logic [wps_pkg::SD_W-1:0]      out_std_dev,
  output logic [wps_pkg::SD_W-1:0]      out_mean_error,
  output logic [1:0]                    out_status
);
  import wps_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_FILL  = 13'h0002,
    S_FILL2 = 13'h0004,
    S_SCL1  = 13'h0008,
    S_SCL2  = 13'h0010,
    S_STATS = 13'h0020,
    S_MDIV  = 13'h0040,
    S_MULA  = 13'h0080,
    S_MULB  = 13'h0100,
    S_VDIV  = 13'h0200,
    S_EDIV  = 13'h0400,
    S_SQ2   = 13'h0800,
    S_DONE  = 13'h1000
  } state_t;

  function automatic logic [SUM_W-1:0] sat_add_s(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] r;
    r = a + b;
    if (a[SUM_W-1] == b[SUM_W-1] && r[SUM_W-1] != a[SUM_W-1])
      r = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    return r;
  endfunction

  function automatic logic [SQ_W-1:0] sat_add_u(input logic [SQ_W-1:0] a,
                                                input logic [SQ_W-1:0] b);
    logic [SQ_W:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[SQ_W] ? SQ_MAX : r[SQ_W-1:0];
  endfunction

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SQ_W-1:0]   sq_r;
  logic [VW-1:0]     vmag_r;
  logic              vneg_r, fneg_r;
  logic [WW-1:0]     w_r;
  logic [2*SFW-1:0]  fmsq_r;
  logic [2*VW-1:0]   vsq_r;
  logic [DIV_W-1:0]  pa_r;
  logic [2*CW-1:0]   den_r;
  logic [MEAN_W-1:0] mean_r;
  logic [SD_W-1:0]   sdev_r, merr_r;
  status_t           st_r;
  logic              out_valid_r;
  logic [31:0]       out_count_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic [SD_W-1:0]   out_sdev_r, out_merr_r;
  status_t           out_status_r;

  logic              in_accept, out_load;
  logic [SUM_W-1:0]  smag;
  logic [VW-1:0]     vmag_in;
  logic [SFW-1:0]    fmag_in;

  // serial units
  logic                 mul_start, div_start, sqr_start;
  logic [MUL_W-1:0]     mul_a, mul_b, div_den;
  logic [2*MUL_W-1:0]   mul_prod;
  logic [DIV_W-1:0]     div_num, div_q, sqr_src;
  logic [STEP_W-1:0]    div_steps;
  unit_stat_t           mul_st, div_st;

  // square root unit state
  logic [49:0]       sqr_rem_r;
  logic [47:0]       sqr_root_r;
  logic [DIV_W-1:0]  sqr_src_r;
  logic [5:0]        sqr_cnt_r;
  logic              sqr_run_r, sqr_done_r;
  logic [51:0]       sqr_rem2, sqr_trial, sqr_dif;
  logic              sqr_ge;
  logic [SD_W-1:0]   sqr_res;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign smag    = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign vmag_in = in_value[VW-1] ? (~in_value + 1'b1) : in_value;
  assign fmag_in = in_scale_factor[SFW-1] ? (~in_scale_factor + 1'b1) : in_scale_factor;

  wps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_st),
    .prod  (mul_prod)
  );

  wps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .stat  (div_st),
    .quo   (div_q)
  );

  // fill update terms
  logic [VW+WW-1:0]  fp;
  logic [SUM_W-1:0]  fp_s;
  logic [FP_W-1:0]   fsq_full;
  logic [FP_W-9:0]   fsq;
  logic [SQ_W-1:0]   fsq_c;

  always_comb begin
    fp       = vmag_r * w_r;
    fp_s     = vneg_r ? (~SUM_W'(fp) + 1'b1) : SUM_W'(fp);
    fsq_full = FP_W'(vsq_r) * FP_W'(w_r) + FP_W'(128);
    fsq      = fsq_full[FP_W-1:8];
    fsq_c    = (fsq > (FP_W-8)'(SQ_MAX)) ? SQ_MAX : SQ_W'(fsq);
  end

  // merge update terms
  logic [CW:0] mcnt;
  assign mcnt = (CW+1)'(cnt_r) + (CW+1)'(in_merge_count);

  // scale results from the serial product
  logic [95:0]      sc_t;
  logic [79:0]      sc_p;
  logic             sc_neg;
  logic [SUM_W-1:0] sc_lim, sc_m, sc_sum;
  logic [127:0]     sq_t;
  logic [95:0]      sq_p;
  logic [SQ_W-1:0]  sc_sq;

  always_comb begin
    sc_t   = mul_prod[95:0] + 96'h8000;
    sc_p   = sc_t[95:16];
    sc_neg = sum_r[SUM_W-1] ^ fneg_r;
    sc_lim = sc_neg ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    sc_m   = (sc_p > 80'(sc_lim)) ? sc_lim : sc_p[SUM_W-1:0];
    sc_sum = sc_neg ? (~sc_m + 1'b1) : sc_m;
    sq_t   = mul_prod + 128'h8000_0000;
    sq_p   = sq_t[127:32];
    sc_sq  = (sq_p > 96'(SQ_MAX)) ? SQ_MAX : sq_p[SQ_W-1:0];
  end

  // mean rounding and clamp, variance numerator
  logic [MEAN_W-1:0] mean_calc;
  logic [127:0]      va_sh, va_dif;
  logic              negvar;

  always_comb begin
    if (sum_r[SUM_W-1]) begin
      if (div_q > (DIV_W'(1) << (MEAN_W-1)))
        mean_calc = {1'b1, {(MEAN_W-1){1'b0}}};
      else
        mean_calc = ~div_q[MEAN_W-1:0] + 1'b1;
    end else begin
      if (div_q > DIV_W'({(MEAN_W-1){1'b1}}))
        mean_calc = {1'b0, {(MEAN_W-1){1'b1}}};
      else
        mean_calc = div_q[MEAN_W-1:0];
    end
    va_sh  = {16'b0, pa_r, 16'b0};
    negvar = (va_sh < mul_prod);
    va_dif = va_sh - mul_prod;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = smag;
    mul_b     = MUL_W'(fmag_in);
    div_start = 1'b0;
    div_num   = {smag + SUM_W'(cnt_r >> 1), 32'b0};
    div_den   = MUL_W'(cnt_r);
    div_steps = STEP_W'(64);
    sqr_start = 1'b0;
    sqr_src   = div_q;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_req_type)
            REQ_FILL:  state_nxt = S_FILL;
            REQ_SCALE: begin
              mul_start = 1'b1;
              state_nxt = S_SCL1;
            end
            default:   state_nxt = S_STATS;
          endcase
        end
      end
      S_FILL:  state_nxt = S_FILL2;
      S_FILL2: state_nxt = S_STATS;
      S_SCL1: begin
        if (mul_st.done) begin
          mul_start = 1'b1;
          mul_a     = MUL_W'(sq_r);
          mul_b     = MUL_W'(fmsq_r);
          state_nxt = S_SCL2;
        end
      end
      S_SCL2: begin
        if (mul_st.done) state_nxt = S_STATS;
      end
      S_STATS: begin
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_MDIV;
        end
      end
      S_MDIV: begin
        if (div_st.done) begin
          if (cnt_r == CW'(1)) begin
            state_nxt = S_DONE;
          end else begin
            mul_start = 1'b1;
            mul_a     = MUL_W'(sq_r);
            mul_b     = MUL_W'(cnt_r);
            state_nxt = S_MULA;
          end
        end
      end
      S_MULA: begin
        if (mul_st.done) begin
          mul_start = 1'b1;
          mul_a     = smag;
          mul_b     = smag;
          state_nxt = S_MULB;
        end
      end
      S_MULB: begin
        if (mul_st.done) begin
          if (negvar) begin
            state_nxt = S_DONE;
          end else begin
            div_start = 1'b1;
            div_num   = va_dif[111:16];
            div_den   = MUL_W'(den_r);
            div_steps = STEP_W'(DIV_W);
            state_nxt = S_VDIV;
          end
        end
      end
      S_VDIV: begin
        // root of the variance runs beside the division by the count
        if (div_st.done) begin
          sqr_start = 1'b1;
          div_start = 1'b1;
          div_num   = div_q;
          div_steps = STEP_W'(DIV_W);
          state_nxt = S_EDIV;
        end
      end
      S_EDIV: begin
        if (div_st.done) begin
          sqr_start = 1'b1;
          state_nxt = S_SQ2;
        end
      end
      S_SQ2: begin
        if (sqr_done_r) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // serial floor square root, two radicand bits per cycle
  always_comb begin
    sqr_rem2  = {sqr_rem_r, sqr_src_r[DIV_W-1:DIV_W-2]};
    sqr_trial = {2'b00, sqr_root_r, 2'b01};
    sqr_ge    = (sqr_rem2 >= sqr_trial);
    sqr_dif   = sqr_rem2 - sqr_trial;
    sqr_res   = (sqr_root_r[47:SD_W] != '0) ? {SD_W{1'b1}} : sqr_root_r[SD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqr_run_r  <= 1'b0;
      sqr_done_r <= 1'b0;
      sqr_cnt_r  <= '0;
    end else begin
      sqr_done_r <= 1'b0;
      if (sqr_start) begin
        sqr_run_r <= 1'b1;
        sqr_cnt_r <= '0;
      end else if (sqr_run_r) begin
        sqr_cnt_r <= sqr_cnt_r + 1'b1;
        if (sqr_cnt_r == 6'd47) begin
          sqr_run_r  <= 1'b0;
          sqr_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sqr_start) begin
      sqr_src_r  <= sqr_src;
      sqr_rem_r  <= '0;
      sqr_root_r <= '0;
    end else if (sqr_run_r) begin
      sqr_rem_r  <= sqr_ge ? sqr_dif[49:0] : sqr_rem2[49:0];
      sqr_root_r <= {sqr_root_r[46:0], sqr_ge};
      sqr_src_r  <= {sqr_src_r[DIV_W-3:0], 2'b00};
    end
  end

  // control state and bin totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (in_accept && in_req_type == REQ_MERGE) begin
        cnt_r <= (mcnt > (CW+1)'(CNT_MAX)) ? CNT_MAX : mcnt[CW-1:0];
        sum_r <= sat_add_s(sum_r, in_merge_sum);
        sq_r  <= sat_add_u(sq_r, in_merge_sumsq);
      end
      if (state_r == S_FILL) begin
        cnt_r <= (cnt_r != CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
        sum_r <= sat_add_s(sum_r, fp_s);
      end
      if (state_r == S_FILL2) sq_r <= sat_add_u(sq_r, fsq_c);
      if (state_r == S_SCL1 && mul_st.done) sum_r <= sc_sum;
      if (state_r == S_SCL2 && mul_st.done) sq_r <= sc_sq;
    end
  end

  // operand latches, statistics and result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      vmag_r <= vmag_in;
      vneg_r <= in_value[VW-1];
      w_r    <= in_weight;
      fneg_r <= in_scale_factor[SFW-1];
      fmsq_r <= fmag_in * fmag_in;
    end
    if (state_r == S_FILL) vsq_r <= vmag_r * vmag_r;
    if (state_r == S_STATS) begin
      mean_r <= '0;
      sdev_r <= '0;
      merr_r <= '0;
      st_r   <= (cnt_r == '0) ? ST_EMPTY : ST_OK;
      den_r  <= (2*CW)'(cnt_r) * (2*CW)'(cnt_r - 1'b1);
    end
    if (state_r == S_MDIV && div_st.done) begin
      mean_r <= mean_calc;
      if (cnt_r == CW'(1)) st_r <= ST_SINGLE;
    end
    if (state_r == S_MULA && mul_st.done) pa_r <= mul_prod[DIV_W-1:0];
    if (state_r == S_MULB && mul_st.done && negvar) st_r <= ST_NEGVAR;
    if (sqr_done_r && state_r == S_EDIV) sdev_r <= sqr_res;
    if (sqr_done_r && state_r == S_SQ2) merr_r <= sqr_res;
    if (out_load) begin
      out_count_r  <= 32'(cnt_r);
      out_mean_r   <= mean_r;
      out_sdev_r   <= sdev_r;
      out_merr_r   <= merr_r;
      out_status_r <= st_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_count      = out_count_r;
  assign out_mean       = out_mean_r;
  assign out_std_dev    = out_sdev_r;
  assign out_mean_error = out_merr_r;
  assign out_status     = out_status_r;

  // checks
  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_st.busy) else $error("multiplier restarted while busy");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy) else $error("divider restarted while busy");
  a_zero_dev: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && st_r != ST_OK) |-> (sdev_r == '0 && merr_r == '0))
    else $error("deviation reported for invalid bin");
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && st_r == ST_EMPTY) |=> (out_count_r == '0))
    else $error("empty status with nonzero count");

endmodule

// ===== hdl/wps_mul.sv =====
// Bit-serial 64x64 shift-add multiplier, one multiplier bit per cycle.
module wps_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wps_pkg::MUL_W-1:0]   a,
  input  logic [wps_pkg::MUL_W-1:0]   b,
  output wps_pkg::unit_stat_t         stat,
  output logic [2*wps_pkg::MUL_W-1:0] prod
);
  import wps_pkg::*;

  logic [2*MUL_W-1:0] acc_r;
  logic [MUL_W-1:0]   a_r, b_r;
  logic [MSTEP_W-1:0] step_r;
  logic               run_r, done_r;
  logic [MUL_W:0]     hi;

  // add the multiplicand into the upper half for a set multiplier bit
  assign hi = {1'b0, acc_r[2*MUL_W-1:MUL_W]} + (b_r[0] ? {1'b0, a_r} : '0);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == {MSTEP_W{1'b1}}) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (run_r) begin
      acc_r <= {hi, acc_r[MUL_W-1:1]};
      b_r   <= {1'b0, b_r[MUL_W-1:1]};
    end
  end

  assign prod      = acc_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule

// ===== hdl/wps_div.sv =====
// Restoring serial divider, one quotient bit per cycle, numerator left aligned.
module wps_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wps_pkg::DIV_W-1:0]   num,
  input  logic [wps_pkg::MUL_W-1:0]   den,
  input  logic [wps_pkg::STEP_W-1:0]  steps,
  output wps_pkg::unit_stat_t         stat,
  output logic [wps_pkg::DIV_W-1:0]   quo
);
  import wps_pkg::*;

  logic [DIV_W-1:0]  num_r, quo_r;
  logic [MUL_W-1:0]  rem_r, den_r;
  logic [STEP_W-1:0] left_r;
  logic              run_r, done_r;
  logic [MUL_W:0]    r_sh, r_dif;
  logic              ge;

  // shift in the next numerator bit and trial subtract
  always_comb begin
    r_sh  = {rem_r, num_r[DIV_W-1]};
    r_dif = r_sh - {1'b0, den_r};
    ge    = (r_sh >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      left_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        left_r <= steps;
      end else if (run_r) begin
        left_r <= left_r - 1'b1;
        if (left_r == STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      quo_r <= '0;
      rem_r <= '0;
    end else if (run_r) begin
      rem_r <= ge ? r_dif[MUL_W-1:0] : r_sh[MUL_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
      num_r <= {num_r[DIV_W-2:0], 1'b0};
    end
  end

  assign quo       = quo_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the weighted profile bin statistics block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wps_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [63:0] SUM_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_NEG_MAX = 64'h8000_0000_0000_0000;
  localparam logic [23:0] SCALE_ONE = 24'h01_0000;
  localparam int RAND_ITEMS = 700;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]       req;
    logic [VW-1:0]    value;
    logic [WW-1:0]    weight;
    logic [SFW-1:0]   scale;
    logic [31:0]      mcount;
    logic [SUM_W-1:0] msum;
    logic [SQ_W-1:0]  msumsq;
  } bin_req_t;

  typedef struct packed {
    logic [31:0]       count;
    logic [MEAN_W-1:0] mean;
    logic [SD_W-1:0]   sdev;
    logic [SD_W-1:0]   merr;
    logic [1:0]        status;
  } bin_res_t;

  typedef struct packed {
    bin_req_t req;
    logic     typed;
    bin_res_t res;
    logic     late;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic [VW-1:0] in_value = '0;
  logic [WW-1:0] in_weight = '0;
  logic [SFW-1:0] in_scale_factor = '0;
  logic [31:0] in_merge_count = '0;
  logic [SUM_W-1:0] in_merge_sum = '0;
  logic [SQ_W-1:0] in_merge_sumsq = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_count;
  logic [MEAN_W-1:0] out_mean;
  logic [SD_W-1:0] out_std_dev;
  logic [SD_W-1:0] out_mean_error;
  logic [1:0] out_status;

  // bin state mirrored by the predictor
  logic [31:0]    bin_cnt = '0;
  logic [63:0]    bin_sum = '0;
  logic [SQ_W-1:0] bin_sq = '0;

  bin_res_t  stats_q[$];
  stim_row_t dir_rows[$];
  logic      cur_typed = 1'b0;
  bin_res_t  cur_exp = '0;
  int        sent_n = 0;
  int        recv_n = 0;
  int        err_n = 0;
  int        status_seen[4];
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  always #6 clk = ~clk;

  weighted_profile_bin_stats DUT (.*);

  function automatic logic [63:0] sum_sat_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? SUM_NEG_MAX : SUM_POS_MAX;
    return r;
  endfunction

  function automatic logic [SQ_W-1:0] sq_sat_add(logic [SQ_W-1:0] a, logic [SQ_W-1:0] b);
    logic [63:0] r;
    r = 64'(a) + 64'(b);
    return (r > 64'(SQ_MAX)) ? SQ_MAX : r[SQ_W-1:0];
  endfunction

  // floor square root of a 128-bit value
  function automatic logic [63:0] root128(logic [127:0] n);
    logic [63:0] r, c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (128'(c) * 128'(c) <= n) r = c;
    end
    return r;
  endfunction

  // apply one request to the bin and work out the reported statistics
  function automatic bin_res_t bin_update(bin_req_t r);
    logic [VW-1:0] vmag;
    logic [SFW-1:0] fmag;
    logic [39:0] prod;
    logic [127:0] w1, w2, d, v;
    logic [63:0] smag, lim, m, den;
    logic [64:0] q;
    logic [32:0] c;
    logic vneg, fneg, rneg;
    bin_res_t o;
    o = '0;
    case (r.req)
      REQ_FILL: begin
        vneg = r.value[VW-1];
        vmag = vneg ? -r.value : r.value;
        prod = 40'(vmag) * 40'(r.weight);
        if (bin_cnt != CNT_MAX) bin_cnt = bin_cnt + 1;
        bin_sum = sum_sat_add(bin_sum, vneg ? -{24'b0, prod} : {24'b0, prod});
        w1 = (128'(vmag) * 128'(vmag) * 128'(r.weight) + 128'd128) >> 8;
        bin_sq = sq_sat_add(bin_sq, (w1 > 128'(SQ_MAX)) ? SQ_MAX : w1[SQ_W-1:0]);
      end
      REQ_SCALE: begin
        fneg = r.scale[SFW-1];
        fmag = fneg ? -r.scale : r.scale;
        rneg = bin_sum[63] ^ fneg;
        smag = bin_sum[63] ? -bin_sum : bin_sum;
        w1 = (128'(smag) * 128'(fmag) + 128'h8000) >> 16;
        lim = rneg ? SUM_NEG_MAX : SUM_POS_MAX;
        m = (w1 > 128'(lim)) ? lim : w1[63:0];
        bin_sum = rneg ? -m : m;
        w2 = (128'(bin_sq) * 128'(fmag) * 128'(fmag) + 128'h8000_0000) >> 32;
        bin_sq = (w2 > 128'(SQ_MAX)) ? SQ_MAX : w2[SQ_W-1:0];
      end
      REQ_MERGE: begin
        c = 33'(bin_cnt) + 33'(r.mcount);
        bin_cnt = (c > 33'(CNT_MAX)) ? CNT_MAX : c[31:0];
        bin_sum = sum_sat_add(bin_sum, r.msum);
        bin_sq = sq_sat_add(bin_sq, r.msumsq);
      end
      default: ;
    endcase

    o.count = bin_cnt;
    smag = bin_sum[63] ? -bin_sum : bin_sum;
    if (bin_cnt == 0) begin
      o.status = ST_EMPTY;
    end else begin
      q = (65'(smag) + 65'(bin_cnt / 2)) / 65'(bin_cnt);
      if (bin_sum[63]) begin
        if (q > (65'd1 << 47)) q = 65'd1 << 47;
        o.mean = -q[MEAN_W-1:0];
      end else begin
        if (q > (65'd1 << 47) - 1) q = (65'd1 << 47) - 1;
        o.mean = q[MEAN_W-1:0];
      end
      if (bin_cnt == 1) begin
        o.status = ST_SINGLE;
      end else begin
        w1 = (128'(bin_sq) * 128'(bin_cnt)) << 16;
        w2 = 128'(smag) * 128'(smag);
        if (w1 < w2) begin
          o.status = ST_NEGVAR;
        end else begin
          d = (w1 - w2) >> 16;
          den = 64'(bin_cnt) * (64'(bin_cnt) - 64'd1);
          v = d / 128'(den);
          m = root128(v);
          o.sdev = (m > 64'hFF_FFFF_FFFF) ? '1 : m[SD_W-1:0];
          m = root128(v / 128'(bin_cnt));
          o.merr = (m > 64'hFF_FFFF_FFFF) ? '1 : m[SD_W-1:0];
          o.status = ST_OK;
        end
      end
    end
    return o;
  endfunction

  function automatic bin_req_t mk_req(logic [1:0] req, logic [VW-1:0] value,
                                      logic [WW-1:0] weight, logic [SFW-1:0] scale,
                                      logic [31:0] mcount, logic [63:0] msum,
                                      logic [SQ_W-1:0] msumsq);
    bin_req_t r;
    r.req = req;
    r.value = value;
    r.weight = weight;
    r.scale = scale;
    r.mcount = mcount;
    r.msum = msum;
    r.msumsq = msumsq;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly well-formed fills with a spread of scales and merges, some unknown requests
  function automatic bin_req_t rand_req();
    bin_req_t r;
    int roll;
    r = mk_req(2'($urandom_range(0, 3)), 24'($urandom), 16'($urandom), 24'($urandom),
               $urandom, rand64(), 63'(rand64()));
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      r.req = REQ_FILL;
      if ($urandom_range(0, 3) != 0) r.value = 24'($urandom_range(0, 65535) - 32768);
      if ($urandom_range(0, 2) == 0) r.weight = 16'h0100;
    end else if (roll < 80) begin
      r.req = REQ_SCALE;
      case ($urandom_range(0, 5))
        0: r.scale = '0;
        1: ;
        default: r.scale = SCALE_ONE + 24'($urandom_range(0, 8191)) - 24'd4096;
      endcase
    end else if (roll < 95) begin
      r.req = REQ_MERGE;
      r.mcount = $urandom_range(0, 8);
      if ($urandom_range(0, 9) != 0) begin
        r.msum = 64'($signed(32'($urandom_range(0, 2000000))) - 1000000) <<< 8;
        r.msumsq = 63'($urandom) << 12;
      end
    end else begin
      r.req = REQ_UNKNOWN;
    end
    return r;
  endfunction

  // one input transfer, with a random idle gap ahead of it
  task automatic send_item(bin_req_t r, logic typed, bin_res_t res);
    int gap;
    int start;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type <= r.req;
    in_value <= r.value;
    in_weight <= r.weight;
    in_scale_factor <= r.scale;
    in_merge_count <= r.mcount;
    in_merge_sum <= r.msum;
    in_merge_sumsq <= r.msumsq;
    cur_typed = typed;
    cur_exp = res;
    in_valid <= 1'b1;
    start = sent_n;
    do @(negedge clk); while (sent_n == start);
  endtask

  // receiver stall
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  // accepted input transfer: predict its statistics
  always @(posedge clk) begin
    bin_res_t p;
    if (rst_n && in_valid && !in_stall) begin
      p = bin_update(mk_req(in_req_type, in_value, in_weight, in_scale_factor,
                            in_merge_count, in_merge_sum, in_merge_sumsq));
      stats_q.push_back(cur_typed ? cur_exp : p);
      sent_n <= sent_n + 1;
    end
  end

  // accepted result transfer: compare with the oldest prediction
  always @(posedge clk) begin
    bin_res_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_count, out_mean, out_std_dev, out_mean_error, out_status};
      recv_n <= recv_n + 1;
      status_seen[out_status]++;
      if (stats_q.size() == 0) begin
        err_n++;
        if (err_n <= MAX_REPORTS) $display("result with no request pending: %p", got);
      end else begin
        want = stats_q.pop_front();
        if (got !== want) begin
          err_n++;
          if (err_n <= MAX_REPORTS)
            $display("mismatch at result %0d\n  exp %p\n  got %p", recv_n, want, got);
        end
      end
    end
  end

  initial begin
    bin_req_t r;
    int phase;
    int per_phase;
    int j;

    // directed rows; expected values typed in where obvious
    dir_rows.push_back('{mk_req(REQ_UNKNOWN, '0, '0, '0, '0, '0, '0), 1'b1,
                         '{32'd0, 48'd0, 40'd0, 40'd0, ST_EMPTY}, 1'b0});
    dir_rows.push_back('{mk_req(REQ_SCALE, '0, '0, SCALE_ONE, '0, '0, '0), 1'b1,
                         '{32'd0, 48'd0, 40'd0, 40'd0, ST_EMPTY}, 1'b0});
    dir_rows.push_back('{mk_req(REQ_MERGE, '0, '0, '0, '0, '0, '0), 1'b1,
                         '{32'd0, 48'd0, 40'd0, 40'd0, ST_EMPTY}, 1'b0});
    dir_rows.push_back('{mk_req(REQ_FILL, 24'h001000, 16'h0100, '0, '0, '0, '0), 1'b1,
                         '{32'd1, 48'h10_0000, 40'd0, 40'd0, ST_SINGLE}, 1'b0});
    dir_rows.push_back('{mk_req(REQ_FILL, 24'h001000, 16'h0100, '0, '0, '0, '0), 1'b1,
                         '{32'd2, 48'h10_0000, 40'd0, 40'd0, ST_OK}, 1'b0});
    dir_rows.push_back('{mk_req(REQ_FILL, 24'h7FFFFF, 16'hFFFF, '0, '0, '0, '0), 1'b0, '0, 1'b0});
    dir_rows.push_back('{mk_req(REQ_FILL, 24'h800000, 16'hFFFF, '0, '0, '0, '0), 1'b0, '0, 1'b0});
    dir_rows.push_back('{mk_req(REQ_FILL, '0, '0, '0, '0, '0, '0), 1'b0, '0, 1'b0});
    dir_rows.push_back('{mk_req(REQ_FILL, 24'hFFFFFF, 16'd1, '0, '0, '0, '0), 1'b0, '0, 1'b0});
    dir_rows.push_back('{mk_req(REQ_SCALE, '0, '0, 24'h7FFFFF, '0, '0, '0), 1'b0, '0, 1'b0});
    dir_rows.push_back('{mk_req(REQ_SCALE, '0, '0, 24'h800000, '0, '0, '0), 1'b0, '0, 1'b0});
    dir_rows.push_back('{mk_req(REQ_SCALE, '0, '0, 24'hFF0000, '0, '0, '0), 1'b0, '0, 1'b0});
    dir_rows.push_back('{mk_req(REQ_SCALE, '0, '0, '0, '0, '0, '0), 1'b0, '0, 1'b0});
    dir_rows.push_back('{mk_req(REQ_MERGE, '0, '0, '0, 32'd3, SUM_POS_MAX, SQ_MAX), 1'b0, '0, 1'b0});
    dir_rows.push_back('{mk_req(REQ_MERGE, '0, '0, '0, 32'd1, SUM_NEG_MAX, SQ_MAX), 1'b0, '0, 1'b0});
    dir_rows.push_back('{mk_req(REQ_SCALE, '0, '0, 24'h008000, '0, '0, '0), 1'b0, '0, 1'b0});
    dir_rows.push_back('{mk_req(REQ_MERGE, '0, '0, '0, 32'd2, 64'hFFFF_FFFF_FFF0_0000, '0),
                         1'b0, '0, 1'b0});
    dir_rows.push_back('{mk_req(REQ_SCALE, '0, '0, '0, '0, '0, '0), 1'b0, '0, 1'b0});
    // count saturation is permanent, so it closes the run
    dir_rows.push_back('{mk_req(REQ_MERGE, '0, '0, '0, 32'hFFFF_FFFF, SUM_NEG_MAX, SQ_MAX),
                         1'b0, '0, 1'b1});
    dir_rows.push_back('{mk_req(REQ_FILL, 24'h7FFFFF, 16'hFFFF, '0, '0, '0, '0), 1'b0, '0, 1'b1});
    dir_rows.push_back('{mk_req(REQ_MERGE, '0, '0, '0, 32'hFFFF_FFFF, SUM_POS_MAX, '0),
                         1'b0, '0, 1'b1});
    dir_rows.push_back('{mk_req(REQ_SCALE, '0, '0, 24'h800000, '0, '0, '0), 1'b0, '0, 1'b1});

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      if (!dir_rows[i].late) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    // idle profiles: none, sender idle, receiver stalling, both
    per_phase = RAND_ITEMS / 4;
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 81 : (phase == 3) ? 32 : 0;
      stall_pct = (phase == 2) ? 81 : (phase == 3) ? 32 : 0;
      for (j = 0; j < per_phase; j++) begin
        r = rand_req();
        send_item(r, 1'b0, '0);
      end
    end

    foreach (dir_rows[i])
      if (dir_rows[i].late) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    in_valid <= 1'b0;

    while (stats_q.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);

    $display("%0d requests sent, %0d results checked under four idle profiles", sent_n, recv_n);
    $display("status seen: ok %0d, empty %0d, single %0d, negative variance %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_SINGLE],
             status_seen[ST_NEGVAR]);
    if (err_n == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", err_n);
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #60ms;
    $display("timeout with %0d results outstanding", stats_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
